[design/i2csrb_pkg.sv]
`default_nettype none

package i2csrb_pkg;

  // Widths of the transaction fields.
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIDX_W  = 6;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned MSIZE_W = 7;
  // Register indexes and pointers are bytes on the bus.
  localparam int unsigned IDX_W   = 8;
  // A memory word holds the read-only mark above the register byte.
  localparam int unsigned WORD_W  = BYTE_W + 1;

  localparam logic [MSIZE_W-1:0] MAP_SIZE_RESET = 7'd64;
  localparam logic [BYTE_W-1:0]  PAST_END_BYTE  = 8'hFF;
  localparam logic [IDX_W-1:0]   IDX_MAX        = 8'd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADDR_READ   = 4'd0,
    MODE_TX_ACK      = 4'd1,
    MODE_TX_NACK     = 4'd2,
    MODE_ADDR_WRITE  = 4'd3,
    MODE_RX_DATA     = 4'd4,
    MODE_STOP        = 4'd5,
    MODE_RX_NACK     = 4'd6,
    MODE_TX_LAST_ACK = 4'd7,
    MODE_BUS_ERROR   = 4'd8,
    MODE_UNKNOWN     = 4'd9,
    MODE_LOCAL_WRITE = 4'd10,
    MODE_LOCAL_READ  = 4'd11
  } mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_RX_NACK   = 3'd1,
    ERR_LAST_ACK  = 3'd2,
    ERR_BUS_ERROR = 3'd3,
    ERR_UNKNOWN   = 3'd4
  } err_t;

  // Request from the sequencer to the register memory.
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

[design/i2csrb_if.sv]
`default_nettype none

// Bus event channel.
interface i2csrb_evt_if;
  logic                                valid;
  logic                                ready;
  logic [i2csrb_pkg::MODE_W-1:0]       mode;
  logic [i2csrb_pkg::BYTE_W-1:0]       data_in;
  logic [i2csrb_pkg::LIDX_W-1:0]       local_index;
  logic                                local_readonly;

  modport source (output valid, mode, data_in, local_index, local_readonly, input ready);
  modport sink   (input valid, mode, data_in, local_index, local_readonly, output ready);
endinterface

// Result channel.
interface i2csrb_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [i2csrb_pkg::BYTE_W-1:0]       tx_byte;
  logic                                tx_valid;
  logic                                busy_res;
  logic [i2csrb_pkg::ERR_W-1:0]        error_code;
  logic                                bus_release;
  logic [i2csrb_pkg::BYTE_W-1:0]       local_data;

  modport source (output valid, tx_byte, tx_valid, busy_res, error_code, bus_release,
                  local_data, input ready);
  modport sink   (input valid, tx_byte, tx_valid, busy_res, error_code, bus_release,
                  local_data, output ready);
endinterface

`default_nettype wire

[design/i2csrb_mem.sv]
`default_nettype none

// Register memory: one word per register, read-only mark on top of the byte.
// A per-entry valid bit makes entries read as zero until first written.
module i2csrb_mem #(
  parameter int unsigned REG_COUNT = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire i2csrb_pkg::mem_req_t              req,
  output logic [i2csrb_pkg::WORD_W-1:0]          rd_data
);

  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [i2csrb_pkg::WORD_W-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0]          vld;
  logic [i2csrb_pkg::WORD_W-1:0] rd_word;
  logic                          rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word <= mem[req.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data = rd_vld ? rd_word : '0;

endmodule

`default_nettype wire

[design/i2csrb_ctrl.sv]
`default_nettype none

// Event sequencer: issues the memory read when a transaction is accepted,
// then, once the result register is free, updates the bus state, writes the
// memory back and loads the result register.
module i2csrb_ctrl #(
  parameter int unsigned REG_COUNT = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [i2csrb_pkg::MSIZE_W-1:0]     map_size,
  i2csrb_evt_if.sink                              evt,
  i2csrb_rsp_if.source                            rsp,
  output i2csrb_pkg::mem_req_t                    mem_req,
  input  wire logic [i2csrb_pkg::WORD_W-1:0]      mem_rd_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  localparam logic [i2csrb_pkg::IDX_W-1:0] REG_COUNT_B = i2csrb_pkg::IDX_W'(REG_COUNT);

  state_t state;
  state_t state_next;

  // Bus-side state.
  logic [i2csrb_pkg::IDX_W-1:0] reg_pointer, reg_pointer_next;
  logic [i2csrb_pkg::IDX_W-1:0] tx_index, tx_index_next;
  logic [i2csrb_pkg::IDX_W-1:0] rx_index, rx_index_next;
  logic                         busy, busy_next;
  i2csrb_pkg::err_t             error_latch, error_latch_next;

  // Captured transaction.
  i2csrb_pkg::mode_t             c_mode;
  logic [i2csrb_pkg::BYTE_W-1:0] c_data;
  logic [i2csrb_pkg::LIDX_W-1:0] c_lidx;
  logic                          c_lro;
  logic [i2csrb_pkg::IDX_W-1:0]  c_idx;

  logic                          accept;
  logic                          go;
  logic [i2csrb_pkg::IDX_W-1:0]  rd_addr;
  logic [i2csrb_pkg::IDX_W-1:0]  size;
  logic                          hit;
  logic                          local_ok;
  logic [i2csrb_pkg::IDX_W-1:0]  c_lidx_w;

  logic [i2csrb_pkg::BYTE_W-1:0] txb;
  logic                          txv;
  logic                          rel;
  logic [i2csrb_pkg::BYTE_W-1:0] ldata;
  logic                          wr_en;
  logic [i2csrb_pkg::IDX_W-1:0]  wr_addr;
  logic [i2csrb_pkg::WORD_W-1:0] wr_data;

  assign evt.ready = (state == ST_IDLE);
  assign accept    = evt.valid && evt.ready;
  assign go        = (state == ST_EXEC) && (!rsp.valid || rsp.ready);

  // The read address depends on the event kind and on the current indexes.
  always_comb begin
    unique case (i2csrb_pkg::mode_t'(evt.mode))
      i2csrb_pkg::MODE_ADDR_READ: rd_addr = reg_pointer;
      i2csrb_pkg::MODE_TX_ACK:    rd_addr = tx_index;
      i2csrb_pkg::MODE_RX_DATA:   rd_addr = rx_index;
      default:                    rd_addr = i2csrb_pkg::IDX_W'(evt.local_index);
    endcase
  end

  assign size = ({1'b0, map_size} > REG_COUNT_B) ? REG_COUNT_B : {1'b0, map_size};
  assign hit  = (c_idx < size);
  assign c_lidx_w = i2csrb_pkg::IDX_W'(c_lidx);
  assign local_ok = (c_lidx_w < REG_COUNT_B);

  always_comb begin
    txb              = '0;
    txv              = 1'b0;
    rel              = 1'b0;
    ldata            = '0;
    reg_pointer_next = reg_pointer;
    tx_index_next    = tx_index;
    rx_index_next    = rx_index;
    busy_next        = busy;
    error_latch_next = error_latch;
    wr_en            = 1'b0;
    wr_addr          = c_idx;
    wr_data          = {1'b0, c_data};
    unique case (c_mode)
      i2csrb_pkg::MODE_ADDR_READ, i2csrb_pkg::MODE_TX_ACK: begin
        txv       = 1'b1;
        busy_next = 1'b1;
        if (hit) begin
          txb           = mem_rd_data[i2csrb_pkg::BYTE_W-1:0];
          tx_index_next = c_idx + 1'b1;
        end else begin
          txb           = i2csrb_pkg::PAST_END_BYTE;
          tx_index_next = c_idx;
        end
      end
      i2csrb_pkg::MODE_TX_NACK, i2csrb_pkg::MODE_STOP: begin
        busy_next = 1'b0;
      end
      i2csrb_pkg::MODE_ADDR_WRITE: begin
        rx_index_next = '0;
        busy_next     = 1'b1;
      end
      i2csrb_pkg::MODE_RX_DATA: begin
        busy_next = 1'b1;
        if (c_idx == '0) begin
          // The first byte of a write (or any byte after a zero pointer) is the pointer.
          reg_pointer_next = c_data;
          rx_index_next    = c_data;
        end else begin
          wr_en         = hit && !mem_rd_data[i2csrb_pkg::BYTE_W];
          rx_index_next = (c_idx == i2csrb_pkg::IDX_MAX) ? c_idx : c_idx + 1'b1;
        end
      end
      i2csrb_pkg::MODE_RX_NACK: begin
        error_latch_next = i2csrb_pkg::ERR_RX_NACK;
        rel              = 1'b1;
      end
      i2csrb_pkg::MODE_TX_LAST_ACK: begin
        error_latch_next = i2csrb_pkg::ERR_LAST_ACK;
        rel              = 1'b1;
      end
      i2csrb_pkg::MODE_BUS_ERROR: begin
        error_latch_next = i2csrb_pkg::ERR_BUS_ERROR;
        rel              = 1'b1;
      end
      i2csrb_pkg::MODE_LOCAL_WRITE: begin
        wr_en   = local_ok;
        wr_addr = c_lidx_w;
        wr_data = {c_lro, c_data};
      end
      i2csrb_pkg::MODE_LOCAL_READ: begin
        if (local_ok) begin
          ldata = mem_rd_data[i2csrb_pkg::BYTE_W-1:0];
        end
      end
      default: begin
        error_latch_next = i2csrb_pkg::ERR_UNKNOWN;
        busy_next        = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_req.rd_en   = accept;
    mem_req.rd_addr = rd_addr;
    mem_req.wr_en   = go && wr_en;
    mem_req.wr_addr = wr_addr;
    mem_req.wr_data = wr_data;
  end

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = go ? ST_IDLE : ST_EXEC;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      reg_pointer <= '0;
      tx_index    <= '0;
      rx_index    <= '0;
      busy        <= 1'b0;
      error_latch <= i2csrb_pkg::ERR_NONE;
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (go) begin
        reg_pointer <= reg_pointer_next;
        tx_index    <= tx_index_next;
        rx_index    <= rx_index_next;
        busy        <= busy_next;
        error_latch <= error_latch_next;
        rsp.valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_mode <= i2csrb_pkg::mode_t'(evt.mode);
      c_data <= evt.data_in;
      c_lidx <= evt.local_index;
      c_lro  <= evt.local_readonly;
      c_idx  <= rd_addr;
    end
    if (go) begin
      rsp.tx_byte     <= txb;
      rsp.tx_valid    <= txv;
      rsp.busy_res    <= busy_next;
      rsp.error_code  <= error_latch_next;
      rsp.bus_release <= rel;
      rsp.local_data  <= ldata;
    end
  end

endmodule

`default_nettype wire

[design/i2c_slave_register_bank_top.sv]
// Register-bank back end of an I2C target. Each transaction on the event
// channel is one bus event (address for read or write, a transmitted byte
// acked or nacked, a received byte, a stop, an error kind) or one local access
// by the application, and it produces exactly one transaction on the result
// channel. In the cycle an event is accepted the register memory is read;
// then, once the result register is free, the state is updated, the memory is
// written back and the result is registered. The next event is accepted only
// after that, so the block takes no new event while one is in flight; a
// stalled result holds the block in its execute state. The memory and the
// read-only marks read as zero after reset, with no clearing pass. map_size
// may be written only while the block is idle.
`default_nettype none

module i2c_slave_register_bank_top #(
  parameter int unsigned REG_COUNT = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  i2csrb_evt_if.sink                              evt,
  i2csrb_rsp_if.source                            rsp,
  input  wire logic                               cfg_we,
  input  wire logic [i2csrb_pkg::MSIZE_W-1:0]     cfg_wdata
);

  // Number of registers exposed on the bus; clipped to REG_COUNT in the
  // sequencer.
  logic [i2csrb_pkg::MSIZE_W-1:0]  map_size;

  // Request from the sequencer to the memory, and the registered read word.
  i2csrb_pkg::mem_req_t            mem_req;
  logic [i2csrb_pkg::WORD_W-1:0]   mem_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size <= i2csrb_pkg::MAP_SIZE_RESET;
    end else if (cfg_we) begin
      map_size <= cfg_wdata;
    end
  end

  // Sequencer: owns the pointer, the transmit and receive indexes, the busy
  // flag, the error latch and the result register.
  i2csrb_ctrl #(
    .REG_COUNT (REG_COUNT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .map_size    (map_size),
    .evt         (evt),
    .rsp         (rsp),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  // Register memory with read-only marks.
  i2csrb_mem #(
    .REG_COUNT (REG_COUNT)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

[sim/i2csrb_tb_pkg.sv]
package i2csrb_tb_pkg;
  import i2csrb_pkg::*;

  localparam int unsigned BANK_REGS = 64;

  // Mode codes above the named ones; the block treats them as unknown events.
  localparam logic [MODE_W-1:0] MODE_RESERVED_LO = 4'd12;
  localparam logic [MODE_W-1:0] MODE_RESERVED_HI = 4'd15;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_in;
    logic [LIDX_W-1:0] local_index;
    logic              local_readonly;
  } bank_event_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_valid;
    logic              busy_res;
    logic [ERR_W-1:0]  error_code;
    logic              bus_release;
    logic [BYTE_W-1:0] local_data;
  } bank_reply_t;

  // Shadow copy of the register bank. Every accepted event updates the copy
  // and queues the reply the block owes for it.
  class reg_bank_shadow;
    logic [BYTE_W-1:0]  regs [BANK_REGS];
    bit                 locked [BANK_REGS];
    logic [IDX_W-1:0]   pointer;
    logic [IDX_W-1:0]   tx_pos;
    logic [IDX_W-1:0]   rx_pos;
    logic               busy;
    logic [ERR_W-1:0]   err_latch;
    logic [MSIZE_W-1:0] map_size;
    bank_reply_t        reply_q[$];
    int unsigned        replies_seen;
    int unsigned        errors;

    function new();
      foreach (regs[i]) begin
        regs[i]   = '0;
        locked[i] = 1'b0;
      end
      pointer      = '0;
      tx_pos       = '0;
      rx_pos       = '0;
      busy         = 1'b0;
      err_latch    = ERR_NONE;
      map_size     = MAP_SIZE_RESET;
      replies_seen = 0;
      errors       = 0;
    endfunction

    function void set_map_size(logic [MSIZE_W-1:0] value);
      map_size = value;
    endfunction

    function int unsigned outstanding();
      return reply_q.size();
    endfunction

    function void take_event(bank_event_t ev);
      bank_reply_t r;
      int unsigned span;
      r    = '0;
      span = (map_size > BANK_REGS) ? BANK_REGS : map_size;
      case (ev.mode)
        MODE_ADDR_READ, MODE_TX_ACK: begin
          if (ev.mode == MODE_ADDR_READ) tx_pos = pointer;
          if (tx_pos < span) begin
            r.tx_byte = regs[tx_pos];
            tx_pos    = tx_pos + 1'b1;
          end else begin
            r.tx_byte = PAST_END_BYTE;
          end
          r.tx_valid = 1'b1;
          busy       = 1'b1;
        end
        MODE_TX_NACK, MODE_STOP: busy = 1'b0;
        MODE_ADDR_WRITE: begin
          rx_pos = '0;
          busy   = 1'b1;
        end
        MODE_RX_DATA: begin
          // An index of zero means this byte is a pointer, even right after
          // a pointer byte of zero.
          if (rx_pos == '0) begin
            pointer = ev.data_in;
            rx_pos  = ev.data_in;
          end else begin
            if (rx_pos < span && !locked[rx_pos]) regs[rx_pos] = ev.data_in;
            if (rx_pos != IDX_MAX) rx_pos = rx_pos + 1'b1;
          end
          busy = 1'b1;
        end
        MODE_RX_NACK: begin
          err_latch     = ERR_RX_NACK;
          r.bus_release = 1'b1;
        end
        MODE_TX_LAST_ACK: begin
          err_latch     = ERR_LAST_ACK;
          r.bus_release = 1'b1;
        end
        MODE_BUS_ERROR: begin
          err_latch     = ERR_BUS_ERROR;
          r.bus_release = 1'b1;
        end
        MODE_LOCAL_WRITE: begin
          if (ev.local_index < BANK_REGS) begin
            regs[ev.local_index]   = ev.data_in;
            locked[ev.local_index] = ev.local_readonly;
          end
        end
        MODE_LOCAL_READ: begin
          if (ev.local_index < BANK_REGS) r.local_data = regs[ev.local_index];
        end
        default: begin
          err_latch = ERR_UNKNOWN;
          busy      = 1'b0;
        end
      endcase
      r.busy_res   = busy;
      r.error_code = err_latch;
      reply_q.push_back(r);
    endfunction

    function void check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        $error("reply %0d %s: expected 0x%0h, got 0x%0h", replies_seen, name, want, got);
        errors++;
      end
    endfunction

    function void match_reply(bank_reply_t got);
      bank_reply_t want;
      replies_seen++;
      if (reply_q.size() == 0) begin
        $error("reply %0d arrived with no event outstanding", replies_seen);
        errors++;
        return;
      end
      want = reply_q.pop_front();
      check_field("tx_byte", want.tx_byte, got.tx_byte);
      check_field("tx_valid", want.tx_valid, got.tx_valid);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("error_code", want.error_code, got.error_code);
      check_field("bus_release", want.bus_release, got.bus_release);
      check_field("local_data", want.local_data, got.local_data);
    endfunction
  endclass

endpackage

[sim/tb_i2c_slave_register_bank_top.sv]
module tb_i2c_slave_register_bank_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2csrb_pkg::*;
  import i2csrb_tb_pkg::*;

  // Events per random phase; eight phases plus the directed part come to
  // roughly 1650 events.
  localparam int unsigned PHASE_EVENTS   = 205;
  // Length of the long receiver hold-off that backs the block up.
  localparam int unsigned HOLD_CYCLES    = 400;
  // Cycles without any transaction on either channel before giving up.
  // The longest correct quiet stretch is the hold-off above.
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [MSIZE_W-1:0] cfg_wdata = '0;

  // Shared knobs between the stimulus and the receiver. A calm side never
  // idles, which gives stretches of back-to-back traffic.
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;
  bit hold_request = 1'b0;

  int unsigned events_sent = 0;
  int unsigned stall_cycles = 0;

  reg_bank_shadow shadow = new();

  i2csrb_evt_if evt ();
  i2csrb_rsp_if rsp ();

  i2c_slave_register_bank_top #(
    .REG_COUNT(BANK_REGS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  // Both channels are observed at the rising edge. Inputs change only at the
  // falling edge, so the values seen here are the ones the block samples.
  // An event is noted before a reply is matched; a reply can never belong to
  // an event accepted at the same edge since the result is registered after it.
  always @(posedge clk) begin : channel_monitor
    bank_event_t ev;
    bank_reply_t rp;
    bit          moved;
    moved = 1'b0;
    if (!rst) begin
      if (evt.valid && evt.ready) begin
        ev.mode           = evt.mode;
        ev.data_in        = evt.data_in;
        ev.local_index    = evt.local_index;
        ev.local_readonly = evt.local_readonly;
        shadow.take_event(ev);
        moved = 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        rp.tx_byte     = rsp.tx_byte;
        rp.tx_valid    = rsp.tx_valid;
        rp.busy_res    = rsp.busy_res;
        rp.error_code  = rsp.error_code;
        rp.bus_release = rsp.bus_release;
        rp.local_data  = rsp.local_data;
        shadow.match_reply(rp);
        moved = 1'b1;
      end
      // The watchdog only looks at progress, so it also catches a reply that
      // never comes while the stimulus waits for the queue to empty.
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL i2c_slave_register_bank_top");
          $finish;
        end
      end
    end
  end

  // Receiver side. It stalls at random, never when calm, and once holds
  // ready low for a long stretch so that the block fills and blocks its input.
  initial begin : reply_sink
    int gap;
    rsp.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp.ready    = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = sink_calm ? 0 : pick_gap();
        if (gap == 0) begin
          rsp.ready = 1'b1;
          @(negedge clk);
        end else begin
          rsp.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // Offers one event transaction and returns at the falling edge after it was
  // accepted. Valid stays high when no idle gap follows, so back-to-back
  // events only change the payload.
  task automatic put_event(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data,
                           logic [LIDX_W-1:0] lidx, logic ro);
    int gap;
    evt.mode           = mode;
    evt.data_in        = data;
    evt.local_index    = lidx;
    evt.local_readonly = ro;
    evt.valid          = 1'b1;
    do @(posedge clk); while (!evt.ready);
    @(negedge clk);
    events_sent++;
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      evt.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Lowers valid and waits until every reply owed has come back, plus a few
  // cycles so the block is surely idle before the register changes.
  task automatic drain_replies();
    evt.valid = 1'b0;
    while (shadow.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_map_size(logic [MSIZE_W-1:0] value);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow.set_map_size(value);
    @(negedge clk);
  endtask

  // A bus write: address, a pointer byte, some data bytes and usually a stop.
  // Unused fields carry random bits since the block must ignore them.
  task automatic bus_write_burst();
    int               roll;
    int               count;
    logic [BYTE_W-1:0] ptr;
    put_event(MODE_ADDR_WRITE, $urandom, $urandom, $urandom);
    roll = $urandom_range(0, 9);
    // A zero pointer byte leaves the index at zero, so the next byte is
    // taken as the pointer again.
    if (roll == 0) put_event(MODE_RX_DATA, 8'h00, $urandom, $urandom);
    roll = $urandom_range(0, 9);
    if (roll < 7) ptr = $urandom_range(0, 70);
    else if (roll < 8) ptr = $urandom_range(250, 255);
    else ptr = $urandom;
    put_event(MODE_RX_DATA, ptr, $urandom, $urandom);
    count = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
    repeat (count) put_event(MODE_RX_DATA, $urandom, $urandom, $urandom);
    roll = $urandom_range(0, 9);
    if (roll < 8) begin
      put_event(MODE_STOP, $urandom, $urandom, $urandom);
    end else if (roll == 8) begin
      put_event(MODE_RX_NACK, $urandom, $urandom, $urandom);
      put_event(MODE_STOP, $urandom, $urandom, $urandom);
    end
  endtask

  // A bus read from the current pointer, sometimes long enough to run past
  // the end of the map, usually closed by a nack or an acked last byte.
  task automatic bus_read_burst();
    int roll;
    int count;
    put_event(MODE_ADDR_READ, $urandom, $urandom, $urandom);
    count = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 70) : $urandom_range(0, 6);
    repeat (count) put_event(MODE_TX_ACK, $urandom, $urandom, $urandom);
    roll = $urandom_range(0, 9);
    if (roll < 7) put_event(MODE_TX_NACK, $urandom, $urandom, $urandom);
    else if (roll < 9) put_event(MODE_TX_LAST_ACK, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 4) != 0) put_event(MODE_STOP, $urandom, $urandom, $urandom);
  endtask

  // One random phase: mostly well-formed bus transfers, mixed with local accesses
  // by the application and some plain noise over all sixteen mode codes.
  task automatic run_phase(int unsigned quota);
    int unsigned start;
    int          roll;
    start = events_sent;
    while (events_sent - start < quota) begin
      if ($urandom_range(0, 15) == 0) begin
        src_calm  = ($urandom_range(0, 2) == 0);
        sink_calm = ($urandom_range(0, 2) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        bus_write_burst();
      end else if (roll < 65) begin
        bus_read_burst();
      end else if (roll < 78) begin
        put_event(MODE_LOCAL_WRITE, $urandom, $urandom, ($urandom_range(0, 3) == 0));
      end else if (roll < 88) begin
        put_event(MODE_LOCAL_READ, $urandom, $urandom, $urandom);
      end else begin
        put_event($urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    logic [MSIZE_W-1:0] sizes [8];
    sizes = '{7'd0, 7'd127, 7'd1, 7'd63, 7'd65, MAP_SIZE_RESET, 7'd0, 7'd0};
    sizes[6] = $urandom_range(2, 62);
    sizes[7] = $urandom;

    evt.valid          = 1'b0;
    evt.mode           = MODE_STOP;
    evt.data_in        = '0;
    evt.local_index    = '0;
    evt.local_readonly = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with the map size at its reset value. The memory reads
    // as zero after reset, then a few registers are loaded, one at the top
    // of the map marked read-only.
    put_event(MODE_LOCAL_READ, 8'h00, 6'd0, 1'b0);
    put_event(MODE_LOCAL_WRITE, 8'hFF, 6'd63, 1'b1);
    put_event(MODE_LOCAL_WRITE, 8'hA5, 6'd0, 1'b0);
    put_event(MODE_LOCAL_WRITE, 8'h00, 6'd62, 1'b0);
    // Read from pointer zero before any error has been latched.
    put_event(MODE_ADDR_READ, 8'h00, 6'd0, 1'b0);
    put_event(MODE_TX_ACK, 8'h00, 6'd0, 1'b0);
    put_event(MODE_TX_NACK, 8'h00, 6'd0, 1'b0);
    // Write: a zero pointer is taken as a pointer again, then pointer 62,
    // a normal write, a write to the read-only register and one past the end.
    put_event(MODE_ADDR_WRITE, 8'h00, 6'd0, 1'b0);
    put_event(MODE_RX_DATA, 8'h00, 6'd0, 1'b0);
    put_event(MODE_RX_DATA, 8'd62, 6'd0, 1'b0);
    put_event(MODE_RX_DATA, 8'h3C, 6'd0, 1'b0);
    put_event(MODE_RX_DATA, 8'h11, 6'd0, 1'b0);
    put_event(MODE_RX_DATA, 8'h22, 6'd0, 1'b0);
    put_event(MODE_STOP, 8'h00, 6'd0, 1'b0);
    // Read back from 62 and on past the map end.
    put_event(MODE_ADDR_READ, 8'h00, 6'd0, 1'b0);
    put_event(MODE_TX_ACK, 8'h00, 6'd0, 1'b0);
    put_event(MODE_TX_ACK, 8'h00, 6'd0, 1'b0);
    put_event(MODE_TX_LAST_ACK, 8'h00, 6'd0, 1'b0);
    // Pointer 255: the receive index sits at its ceiling and stays there.
    put_event(MODE_ADDR_WRITE, 8'h00, 6'd0, 1'b0);
    put_event(MODE_RX_DATA, 8'hFF, 6'd0, 1'b0);
    put_event(MODE_RX_DATA, 8'h5A, 6'd0, 1'b0);
    put_event(MODE_RX_DATA, 8'hC3, 6'd0, 1'b0);
    put_event(MODE_LOCAL_READ, 8'h00, 6'd63, 1'b1);
    // Remaining error kinds, the unknown event and two reserved mode codes.
    put_event(MODE_RX_NACK, 8'h00, 6'd0, 1'b0);
    put_event(MODE_BUS_ERROR, 8'h00, 6'd0, 1'b0);
    put_event(MODE_UNKNOWN, 8'h00, 6'd0, 1'b0);
    put_event(MODE_RESERVED_HI, 8'h00, 6'd0, 1'b0);
    put_event(MODE_RESERVED_LO, 8'h00, 6'd0, 1'b0);
    drain_replies();

    // Random phases, each under its own map size. The register changes only
    // once the block has returned every reply. In the second phase the
    // receiver takes its long hold-off while events keep coming.
    foreach (sizes[i]) begin
      write_map_size(sizes[i]);
      if (i == 1) hold_request = 1'b1;
      run_phase(PHASE_EVENTS);
      drain_replies();
    end

    repeat (10) @(negedge clk);
    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("PASS i2c_slave_register_bank_top");
    end else begin
      $display("FAIL i2c_slave_register_bank_top");
    end
    $finish;
  end

endmodule

[files.f]
design/i2csrb_pkg.sv
design/i2csrb_if.sv
design/i2csrb_mem.sv
design/i2csrb_ctrl.sv
design/i2c_slave_register_bank_top.sv
sim/i2csrb_tb_pkg.sv
sim/tb_i2c_slave_register_bank_top.sv
